[sv/qxmm_pkg.sv]
// qxmm_pkg: shared widths, register codes, reset values and mix signs
// for the quad-X motor mixer; no dependencies
`timescale 1ns / 1ps

package qxmm_pkg;

  localparam int unsigned ValW     = 11;  // throttle, stick and motor values
  localparam int unsigned TermW    = 12;  // signed roll, pitch, yaw terms
  localparam int unsigned SumW     = 15;  // exact four-term mix
  localparam int unsigned ShiftW   = 16;  // mix after the excess shift
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned NumMotors = 4;

  typedef enum logic [CfgAddrW-1:0] {
    CfgMinThrottle = 3'd0,
    CfgMaxThrottle = 3'd1,
    CfgMinCommand  = 3'd2,
    CfgMinCheck    = 3'd3,
    CfgYawReverse  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ValW-1:0] min_throttle;
    logic [ValW-1:0] max_throttle;
    logic [ValW-1:0] min_command;
    logic [ValW-1:0] min_check;
    logic            yaw_reverse;
  } cfg_t;

  localparam logic [ValW-1:0] MinThrottleRst = 11'd1150;
  localparam logic [ValW-1:0] MaxThrottleRst = 11'd1850;
  localparam logic [ValW-1:0] MinCommandRst  = 11'd1000;
  localparam logic [ValW-1:0] MinCheckRst    = 11'd1100;

  // motor order: rear right, front right, rear left, front left
  // a set bit subtracts the term for that motor
  localparam logic [NumMotors-1:0] RollNeg  = 4'b0011;
  localparam logic [NumMotors-1:0] PitchNeg = 4'b1010;
  localparam logic [NumMotors-1:0] YawNeg   = 4'b1001;

  typedef enum logic [1:0] {
    MotorRearRight  = 2'd0,
    MotorFrontRight = 2'd1,
    MotorRearLeft   = 2'd2,
    MotorFrontLeft  = 2'd3
  } motor_e;

  // lower bound checked first, so with lo > hi values below lo give lo and all others give hi
  function automatic logic [ValW-1:0] clamp_motor(input logic signed [ShiftW-1:0] v,
                                                  input logic [ValW-1:0] lo,
                                                  input logic [ValW-1:0] hi);
    logic signed [ShiftW-1:0] lo_s;
    logic signed [ShiftW-1:0] hi_s;
    lo_s = signed'({{(ShiftW-ValW){1'b0}}, lo});
    hi_s = signed'({{(ShiftW-ValW){1'b0}}, hi});
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[ValW-1:0];
    end
  endfunction

endpackage

[sv/quad_x_motor_mixer_top.sv]
// Mixes a throttle command and roll/pitch/yaw terms into four quad-X motor
// values. An item is accepted on any cycle in which in_valid_i and in_ready_o
// are high; its result is offered once the item has passed the input register
// and then the result register. These two registers bound one stage of mix,
// excess shift and clamp logic, so the block sustains one item per clock; a
// stalled output backs up through both registers, one transfer at a time.
// Configuration registers are written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i and must only change while idle. Depends on qxmm_pkg.
`timescale 1ns / 1ps

module quad_x_motor_mixer_top
  import qxmm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [CfgAddrW-1:0]        cfg_addr_i,
  input  logic [ValW-1:0]            cfg_wdata_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ValW-1:0]            throttle_cmd_i,
  input  logic signed [TermW-1:0]    roll_term_i,
  input  logic signed [TermW-1:0]    pitch_term_i,
  input  logic signed [TermW-1:0]    yaw_term_i,
  input  logic [ValW-1:0]            stick_throttle_i,
  input  logic                       baro_hold_i,
  input  logic                       armed_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ValW-1:0]            rear_right_o,
  output logic [ValW-1:0]            front_right_o,
  output logic [ValW-1:0]            rear_left_o,
  output logic [ValW-1:0]            front_left_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_throttle <= MinThrottleRst;
      cfg_q.max_throttle <= MaxThrottleRst;
      cfg_q.min_command  <= MinCommandRst;
      cfg_q.min_check    <= MinCheckRst;
      cfg_q.yaw_reverse  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgMinThrottle: cfg_q.min_throttle <= cfg_wdata_i;
        CfgMaxThrottle: cfg_q.max_throttle <= cfg_wdata_i;
        CfgMinCommand:  cfg_q.min_command  <= cfg_wdata_i;
        CfgMinCheck:    cfg_q.min_check    <= cfg_wdata_i;
        CfgYawReverse:  cfg_q.yaw_reverse  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_q;
  logic s2_load;
  logic in_xfer;

  assign s2_load    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // input register
  logic [ValW-1:0]         thr_q;
  logic signed [TermW-1:0] roll_q;
  logic signed [TermW-1:0] pitch_q;
  logic signed [TermW-1:0] yaw_q;
  logic [ValW-1:0]         stick_q;
  logic                    baro_q;
  logic                    armed_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      thr_q   <= throttle_cmd_i;
      roll_q  <= roll_term_i;
      pitch_q <= pitch_term_i;
      yaw_q   <= yaw_term_i;
      stick_q <= stick_throttle_i;
      baro_q  <= baro_hold_i;
      armed_q <= armed_i;
    end
  end

  // mix, excess shift, clamp, with the disarmed and low-stick overrides
  logic signed [SumW-1:0]   thr_s;
  logic signed [SumW-1:0]   roll_s;
  logic signed [SumW-1:0]   pitch_s;
  logic signed [SumW-1:0]   yaw_s;
  logic signed [SumW-1:0]   mix   [NumMotors];
  logic signed [SumW-1:0]   top01;
  logic signed [SumW-1:0]   top23;
  logic signed [SumW-1:0]   top;
  logic signed [ShiftW-1:0] hi_s;
  logic signed [ShiftW-1:0] excess;
  logic signed [ShiftW-1:0] shifted [NumMotors];
  logic [ValW-1:0]          motor_d [NumMotors];
  logic                     low_stick;

  always_comb begin
    thr_s   = signed'({{(SumW-ValW){1'b0}}, thr_q});
    roll_s  = SumW'(roll_q);
    pitch_s = SumW'(pitch_q);
    yaw_s   = cfg_q.yaw_reverse ? -SumW'(yaw_q) : SumW'(yaw_q);

    for (int i = 0; i < NumMotors; i++) begin
      mix[i] = thr_s
             + (RollNeg[i]  ? -roll_s  : roll_s)
             + (PitchNeg[i] ? -pitch_s : pitch_s)
             + (YawNeg[i]   ? -yaw_s   : yaw_s);
    end

    top01 = (mix[1] > mix[0]) ? mix[1] : mix[0];
    top23 = (mix[3] > mix[2]) ? mix[3] : mix[2];
    top   = (top23 > top01) ? top23 : top01;

    hi_s   = signed'({{(ShiftW-ValW){1'b0}}, cfg_q.max_throttle});
    excess = (ShiftW'(top) > hi_s) ? (ShiftW'(top) - hi_s) : '0;

    low_stick = (stick_q < cfg_q.min_check) && !baro_q;

    for (int i = 0; i < NumMotors; i++) begin
      shifted[i] = ShiftW'(mix[i]) - excess;
      if (!armed_q) begin
        motor_d[i] = cfg_q.min_command;
      end else if (low_stick) begin
        motor_d[i] = cfg_q.min_throttle;
      end else begin
        motor_d[i] = clamp_motor(shifted[i], cfg_q.min_throttle, cfg_q.max_throttle);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      rear_right_o  <= motor_d[MotorRearRight];
      front_right_o <= motor_d[MotorFrontRight];
      rear_left_o   <= motor_d[MotorRearLeft];
      front_left_o  <= motor_d[MotorFrontLeft];
    end
  end

  // checks
  a_disarmed_min_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && !armed_q) |=>
      (rear_right_o == $past(cfg_q.min_command)) && (front_left_o == $past(cfg_q.min_command)))
    else $error("disarmed result is not min_command");

  a_armed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_load && armed_q && (cfg_q.min_throttle <= cfg_q.max_throttle)) |=>
      (rear_left_o <= $past(cfg_q.max_throttle)) && (rear_left_o >= $past(cfg_q.min_throttle)))
    else $error("armed result outside throttle range");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_load) |=> s1_valid_q && $stable(thr_q) && $stable(roll_q))
    else $error("stalled item lost from input register");

endmodule

[verif/qxmm_mix_checker.sv]
// qxmm_mix_checker: watches the quad-X motor mixer channels, predicts the four
// motor values of every accepted command and compares them in order
// depends on qxmm_pkg
`timescale 1ns / 1ps

module qxmm_mix_checker
  import qxmm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [ValW-1:0]         cfg_wdata_i,

  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ValW-1:0]         throttle_cmd_i,
  input  logic signed [TermW-1:0] roll_term_i,
  input  logic signed [TermW-1:0] pitch_term_i,
  input  logic signed [TermW-1:0] yaw_term_i,
  input  logic [ValW-1:0]         stick_throttle_i,
  input  logic                    baro_hold_i,
  input  logic                    armed_i,

  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [ValW-1:0]         rear_right_i,
  input  logic [ValW-1:0]         front_right_i,
  input  logic [ValW-1:0]         rear_left_i,
  input  logic [ValW-1:0]         front_left_i,

  output int                      fail_count_o,
  output int                      pending_o
);

  typedef logic [NumMotors-1:0][ValW-1:0] motor_vals_t;

  string motor_name [NumMotors] = '{"rear_right", "front_right", "rear_left", "front_left"};

  cfg_t        cfg_mirror;
  motor_vals_t expected_motors_q [$];
  motor_vals_t want_motors;
  motor_vals_t got_motors;

  function automatic motor_vals_t predict_motors(input logic [ValW-1:0]         thr,
                                                 input logic signed [TermW-1:0] roll,
                                                 input logic signed [TermW-1:0] pitch,
                                                 input logic signed [TermW-1:0] yaw,
                                                 input logic [ValW-1:0]         stick,
                                                 input logic                    baro,
                                                 input logic                    armed);
    int          t;
    int          r;
    int          p;
    int          y;
    int          lo;
    int          hi;
    int          peak;
    int          v;
    int          mix [NumMotors];
    motor_vals_t res;
    t  = int'(thr);
    r  = int'(roll);
    p  = int'(pitch);
    y  = cfg_mirror.yaw_reverse ? -int'(yaw) : int'(yaw);
    lo = int'(cfg_mirror.min_throttle);
    hi = int'(cfg_mirror.max_throttle);
    mix[MotorRearRight]  = t - r + p - y;
    mix[MotorFrontRight] = t - r - p + y;
    mix[MotorRearLeft]   = t + r + p + y;
    mix[MotorFrontLeft]  = t + r - p - y;
    peak = mix[0];
    for (int i = 1; i < NumMotors; i++) begin
      if (mix[i] > peak) begin
        peak = mix[i];
      end
    end
    for (int i = 0; i < NumMotors; i++) begin
      v = mix[i];
      if (peak > hi) begin
        v = v - (peak - hi);
      end
      if (v < lo) begin
        v = lo;
      end else if (v > hi) begin
        v = hi;
      end
      if (stick < cfg_mirror.min_check && !baro) begin
        v = lo;
      end
      if (!armed) begin
        v = int'(cfg_mirror.min_command);
      end
      res[i] = v[ValW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mirror.min_throttle = MinThrottleRst;
      cfg_mirror.max_throttle = MaxThrottleRst;
      cfg_mirror.min_command  = MinCommandRst;
      cfg_mirror.min_check    = MinCheckRst;
      cfg_mirror.yaw_reverse  = 1'b0;
      expected_motors_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_motors_q.size() == 0) begin
          $error("motor result transfer with no command outstanding");
          fail_count_o++;
        end else begin
          want_motors = expected_motors_q.pop_front();
          got_motors[MotorRearRight]  = rear_right_i;
          got_motors[MotorFrontRight] = front_right_i;
          got_motors[MotorRearLeft]   = rear_left_i;
          got_motors[MotorFrontLeft]  = front_left_i;
          for (int i = 0; i < NumMotors; i++) begin
            if (got_motors[i] !== want_motors[i]) begin
              $error("%s: expected %0d, actual %0d", motor_name[i], want_motors[i],
                     got_motors[i]);
              fail_count_o++;
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_motors_q.push_back(predict_motors(throttle_cmd_i, roll_term_i, pitch_term_i,
                                                   yaw_term_i, stick_throttle_i, baro_hold_i,
                                                   armed_i));
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgMinThrottle: cfg_mirror.min_throttle = cfg_wdata_i;
          CfgMaxThrottle: cfg_mirror.max_throttle = cfg_wdata_i;
          CfgMinCommand:  cfg_mirror.min_command  = cfg_wdata_i;
          CfgMinCheck:    cfg_mirror.min_check    = cfg_wdata_i;
          CfgYawReverse:  cfg_mirror.yaw_reverse  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = expected_motors_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
// tb_top: drives commands and register writes into the quad-X motor mixer
// under several idle patterns and gives the verdict
// depends on qxmm_pkg, quad_x_motor_mixer_top and qxmm_mix_checker
`timescale 1ns / 1ps

module tb_top
  import qxmm_pkg::*;
();

  localparam int LongHoldCycles = 400;
  localparam int WatchdogLimit  = 3000;
  localparam int PhaseCmds      = 140;
  localparam logic [CfgAddrW-1:0] CfgFirstUnused = 3'd5;
  localparam logic [CfgAddrW-1:0] CfgLastUnused  = 3'd7;

  typedef struct {
    logic [ValW-1:0]         thr;
    logic signed [TermW-1:0] roll;
    logic signed [TermW-1:0] pitch;
    logic signed [TermW-1:0] yaw;
    logic [ValW-1:0]         stick;
    logic                    baro;
    logic                    armed;
  } mixer_cmd_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgAddrW-1:0]     cfg_addr = '0;
  logic [ValW-1:0]         cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ValW-1:0]         throttle_cmd = '0;
  logic signed [TermW-1:0] roll_term = '0;
  logic signed [TermW-1:0] pitch_term = '0;
  logic signed [TermW-1:0] yaw_term = '0;
  logic [ValW-1:0]         stick_throttle = '0;
  logic                    baro_hold = 1'b0;
  logic                    armed = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ValW-1:0]         rear_right;
  logic [ValW-1:0]         front_right;
  logic [ValW-1:0]         rear_left;
  logic [ValW-1:0]         front_left;

  int   mismatch_total;
  int   cmds_in_flight;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  logic hold_requested = 1'b0;
  logic hold_served = 1'b0;
  int   send_pcts [4] = '{0, 46, 0, 28};
  int   recv_pcts [4] = '{0, 0, 46, 28};

  always #1 clk = ~clk;

  quad_x_motor_mixer_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .throttle_cmd_i   (throttle_cmd),
    .roll_term_i      (roll_term),
    .pitch_term_i     (pitch_term),
    .yaw_term_i       (yaw_term),
    .stick_throttle_i (stick_throttle),
    .baro_hold_i      (baro_hold),
    .armed_i          (armed),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .rear_right_o     (rear_right),
    .front_right_o    (front_right),
    .rear_left_o      (rear_left),
    .front_left_o     (front_left)
  );

  qxmm_mix_checker mix_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .throttle_cmd_i   (throttle_cmd),
    .roll_term_i      (roll_term),
    .pitch_term_i     (pitch_term),
    .yaw_term_i       (yaw_term),
    .stick_throttle_i (stick_throttle),
    .baro_hold_i      (baro_hold),
    .armed_i          (armed),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .rear_right_i     (rear_right),
    .front_right_i    (front_right),
    .rear_left_i      (rear_left),
    .front_left_i     (front_left),
    .fail_count_o     (mismatch_total),
    .pending_o        (cmds_in_flight)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requested && !hold_served) begin
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        hold_served = 1'b1;
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic mixer_cmd_t mk_cmd(input int thr, input int roll, input int pitch,
                                        input int yaw, input int stick, input int baro,
                                        input int arm);
    mixer_cmd_t c;
    c.thr   = thr[ValW-1:0];
    c.roll  = roll[TermW-1:0];
    c.pitch = pitch[TermW-1:0];
    c.yaw   = yaw[TermW-1:0];
    c.stick = stick[ValW-1:0];
    c.baro  = baro[0];
    c.armed = arm[0];
    return c;
  endfunction

  function automatic int rand_term();
    if ($urandom_range(0, 3) == 0) begin
      return int'($urandom_range(0, 4095)) - 2048;
    end
    return int'($urandom_range(0, 800)) - 400;
  endfunction

  function automatic mixer_cmd_t rand_cmd();
    int thr;
    int stick;
    thr   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047) : $urandom_range(1000, 1900);
    stick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047) : $urandom_range(1100, 2000);
    return mk_cmd(thr, rand_term(), rand_term(), rand_term(), stick,
                  int'($urandom_range(0, 3) == 0), int'($urandom_range(0, 9) != 0));
  endfunction

  function automatic cfg_t make_cfg(input int lo, input int hi, input int cmd, input int chk,
                                    input int yaw_rev);
    cfg_t c;
    c.min_throttle = lo[ValW-1:0];
    c.max_throttle = hi[ValW-1:0];
    c.min_command  = cmd[ValW-1:0];
    c.min_check    = chk[ValW-1:0];
    c.yaw_reverse  = yaw_rev[0];
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    if ($urandom_range(0, 1) == 0) begin
      return make_cfg($urandom_range(900, 1300), $urandom_range(1600, 2000),
                      $urandom_range(800, 1100), $urandom_range(1000, 1200),
                      $urandom_range(0, 1));
    end
    return make_cfg($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 2047), $urandom_range(0, 1));
  endfunction

  task automatic send_cmd(input mixer_cmd_t c);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    throttle_cmd   <= c.thr;
    roll_term      <= c.roll;
    pitch_term     <= c.pitch;
    yaw_term       <= c.yaw;
    stick_throttle <= c.stick;
    baro_hold      <= c.baro;
    armed          <= c.armed;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (cmds_in_flight != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [ValW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic reconfigure(input cfg_t c, input int send_pct, input int recv_pct);
    drain_pipeline();
    write_reg(CfgMinThrottle, c.min_throttle);
    write_reg(CfgMaxThrottle, c.max_throttle);
    write_reg(CfgMinCommand, c.min_command);
    write_reg(CfgMinCheck, c.min_check);
    write_reg(CfgYawReverse, {{(ValW-1){1'b0}}, c.yaw_reverse});
    // unmapped index must leave every register alone
    write_reg(CfgAddrW'($urandom_range(CfgFirstUnused, CfgLastUnused)),
              ValW'($urandom_range(0, 2047)));
    cfg_we <= 1'b0;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_cmd(mk_cmd(1500, 0, 0, 0, 1500, 0, 1));
    send_cmd(mk_cmd(1500, 100, -50, 30, 1500, 0, 1));
    send_cmd(mk_cmd(1800, 300, 200, 100, 1500, 0, 1));
    send_cmd(mk_cmd(1200, -400, -300, 200, 1500, 0, 1));
    send_cmd(mk_cmd(1500, 50, 50, 50, 1099, 0, 1));
    send_cmd(mk_cmd(1500, 50, 50, 50, 1099, 1, 1));
    send_cmd(mk_cmd(1500, 50, 50, 50, 1100, 0, 1));
    send_cmd(mk_cmd(1500, 50, 50, 50, 1500, 0, 0));
    send_cmd(mk_cmd(2047, 2047, 2047, 2047, 2047, 1, 1));
    send_cmd(mk_cmd(0, -2048, -2048, -2048, 0, 0, 1));
    send_cmd(mk_cmd(0, -2048, -2048, -2048, 0, 1, 1));
    send_cmd(mk_cmd(2047, -2048, 2047, -2048, 2047, 0, 1));
    send_cmd(mk_cmd(0, 2047, -2048, 2047, 0, 1, 0));
    send_cmd(mk_cmd(1024, 0, 0, -2048, 2047, 1, 1));
    send_cmd(mk_cmd(1024, 0, 0, 2047, 2047, 0, 1));

    // yaw sign reversed
    reconfigure(make_cfg(1150, 1850, 1000, 1100, 1), 0, 0);
    send_cmd(mk_cmd(1024, 0, 0, -2048, 2047, 1, 1));
    send_cmd(mk_cmd(1024, 0, 0, 2047, 2047, 0, 1));
    send_cmd(mk_cmd(1500, 200, -100, 300, 1500, 0, 1));
    repeat (PhaseCmds) send_cmd(rand_cmd());

    // widest window, negative mix clamps at zero
    reconfigure(make_cfg(0, 2047, 0, 0, 0), 46, 0);
    send_cmd(mk_cmd(0, -2048, -2048, -2048, 0, 0, 1));
    repeat (PhaseCmds) send_cmd(rand_cmd());

    // min above max, plus a long output hold-off to back the pipe up
    reconfigure(make_cfg(2047, 0, 2047, 2047, 1), 0, 46);
    hold_requested = 1'b1;
    send_cmd(mk_cmd(1500, 0, 0, 0, 2047, 0, 1));
    send_cmd(mk_cmd(2047, 2047, -2048, 2047, 2046, 1, 1));
    repeat (PhaseCmds) send_cmd(rand_cmd());

    reconfigure(rand_cfg(), 28, 28);
    repeat (PhaseCmds) send_cmd(rand_cmd());

    for (int k = 0; k < 4; k++) begin
      reconfigure(rand_cfg(), send_pcts[k], recv_pcts[k]);
      repeat (PhaseCmds / 2) send_cmd(rand_cmd());
    end

    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/qxmm_pkg.sv
sv/quad_x_motor_mixer_top.sv
verif/qxmm_mix_checker.sv
verif/tb_top.sv
